>>> hw/rtl/pbd_pkg.sv
// Package for the pin blink and duty controller.
// Holds the request and response types, command and mode codes, and the sequencer states.
// No dependencies.
`default_nettype none

package pbd_pkg;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_TOGGLE = 3'd2;
    localparam logic [2:0] MODE_BLINK  = 3'd3;
    localparam logic [2:0] MODE_DUTY   = 3'd4;

    localparam logic [1:0] AM_STATIC = 2'd0;
    localparam logic [1:0] AM_TOGGLE = 2'd1;
    localparam logic [1:0] AM_POWER  = 2'd2;
    localparam logic [1:0] AM_COUNT  = 2'd3;

    localparam logic [15:0] POWER_PERIOD = 16'd10;
    localparam logic [3:0]  POWER_LIMIT  = 4'd10;
    localparam logic [7:0]  PHASE_WRAP   = 8'd100;

    localparam int MOD_BITS = 8;
    localparam logic [2:0] MOD_LAST = 3'(MOD_BITS - 1);

    typedef struct packed {
        logic [2:0]  mode;
        logic        level;
        logic [15:0] period;
        logic [7:0]  blink_count;
        logic [3:0]  power_level;
    } req_t;

    typedef struct packed {
        logic pin_level;
        logic status;
        logic timer_fired;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_MOD
    } seq_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/pin_blink_and_duty_controller_core.sv
// Top level of the pin blink and duty controller; uses pbd_pkg and pbd_mod_unit.
// A command, or a tick that needs no duty step, answers in the cycle after its request.
// A tick that fires the timer in power mode starts the bit-serial remainder unit, waits in
// ST_MOD until the unit's done pulse, and then registers its answer.
// Takes one request per cycle unless the response stalls, and none while in ST_MOD.
// Reset clears the pin, the timer and all mode state.
`default_nettype none

module pin_blink_and_duty_controller_core
    import pbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    seq_state_t  state_reg, state_next;
    logic [1:0]  amode_reg, amode_next;
    logic        pin_reg, pin_next;
    logic        run_reg, run_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  phase_reg, phase_next;
    logic [3:0]  duty_reg, duty_next;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_load;
    logic        accept;
    logic [16:0] tick_inc;
    logic [7:0]  phase_inc;
    logic [3:0]  new_duty;
    logic        mod_start;
    logic        mod_done;
    logic [3:0]  mod_rem;
    logic [3:0]  mod_div;

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign tick_inc  = {1'b0, tick_reg} + 17'd1;
    assign phase_inc = phase_reg + 8'd1;
    assign new_duty  = POWER_LIMIT - req.power_level;
    assign mod_div   = (duty_reg == 4'd0) ? 4'd1 : duty_reg;

    pbd_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (phase_reg),
        .divisor   (mod_div),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        amode_next  = amode_reg;
        pin_next    = pin_reg;
        run_next    = run_reg;
        period_next = period_reg;
        tick_next   = tick_reg;
        phase_next  = phase_reg;
        duty_next   = duty_reg;
        rsp_load    = 1'b0;
        mod_start   = 1'b0;
        rsp_next    = rsp_reg;
        rsp_next.status      = 1'b0;
        rsp_next.timer_fired = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_load = 1'b1;
                    unique case (req.mode)
                        MODE_TICK:
                        begin
                            if (run_reg)
                            begin
                                if (tick_inc >= {1'b0, period_reg})
                                begin
                                    tick_next = 16'd0;
                                    rsp_next.timer_fired = 1'b1;
                                    unique case (amode_reg)
                                        AM_TOGGLE:
                                        begin
                                            pin_next = !pin_reg;
                                        end
                                        AM_COUNT:
                                        begin
                                            if (phase_reg == 8'd0)
                                            begin
                                                amode_next = AM_STATIC;
                                                pin_next   = 1'b1;
                                                run_next   = 1'b0;
                                            end
                                            else
                                            begin
                                                pin_next = !pin_reg;
                                                if (pin_reg)
                                                begin
                                                    phase_next = phase_reg - 8'd1;
                                                end
                                            end
                                        end
                                        AM_POWER:
                                        begin
                                            rsp_load   = 1'b0;
                                            mod_start  = 1'b1;
                                            state_next = ST_MOD;
                                        end
                                        AM_STATIC:
                                        begin
                                        end
                                    endcase
                                end
                                else
                                begin
                                    tick_next = tick_inc[15:0];
                                end
                            end
                        end
                        MODE_SET:
                        begin
                            run_next   = 1'b0;
                            tick_next  = 16'd0;
                            amode_next = AM_STATIC;
                            pin_next   = req.level;
                        end
                        MODE_TOGGLE:
                        begin
                            if (req.period == 16'd0)
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                amode_next  = AM_TOGGLE;
                                period_next = req.period;
                                tick_next   = 16'd0;
                                run_next    = 1'b1;
                            end
                        end
                        MODE_BLINK:
                        begin
                            if ((req.period == 16'd0) || (req.blink_count == 8'd0))
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else
                            begin
                                amode_next  = AM_COUNT;
                                phase_next  = req.blink_count;
                                pin_next    = 1'b1;
                                period_next = req.period;
                                tick_next   = 16'd0;
                                run_next    = 1'b1;
                            end
                        end
                        MODE_DUTY:
                        begin
                            if (req.power_level >= POWER_LIMIT)
                            begin
                                rsp_next.status = 1'b1;
                            end
                            else if ((amode_reg == AM_POWER) && (duty_reg == new_duty))
                            begin
                            end
                            else
                            begin
                                amode_next  = AM_POWER;
                                duty_next   = new_duty;
                                phase_next  = 8'd0;
                                period_next = POWER_PERIOD;
                                tick_next   = 16'd0;
                                run_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    pin_next   = (mod_rem == 4'd0);
                    phase_next = (phase_inc > PHASE_WRAP) ? 8'd0 : phase_inc;
                    rsp_next.timer_fired = 1'b1;
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
        rsp_next.pin_level = pin_next;
        if (!rsp_load)
        begin
            rsp_next = rsp_reg;
        end
        rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            amode_reg     <= AM_STATIC;
            pin_reg       <= 1'b0;
            run_reg       <= 1'b0;
            period_reg    <= 16'd0;
            tick_reg      <= 16'd0;
            phase_reg     <= 8'd0;
            duty_reg      <= 4'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            amode_reg     <= amode_next;
            pin_reg       <= pin_next;
            run_reg       <= run_next;
            period_reg    <= period_next;
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            duty_reg      <= duty_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pbd_mod_unit.sv
// Remainder unit of the pin blink and duty controller.
// Computes an 8-bit value modulo a 4-bit divisor, one bit per cycle; uses pbd_pkg.
`default_nettype none

module pbd_mod_unit
    import pbd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [7:0] dividend,
    input  wire logic [3:0] divisor,
    output logic            done,
    output logic [3:0]      remainder
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [3:0] rem_reg, rem_next;
    logic [7:0] dvd_reg, dvd_next;
    logic [3:0] div_reg, div_next;
    logic [4:0] trial;
    logic [4:0] diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[7]};
        diff      = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            rem_next  = 4'd0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = diff[3:0];
            end
            else
            begin
                rem_next = trial[3:0];
            end
            dvd_next = {dvd_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == MOD_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> test/pin_blink_and_duty_controller_core_test.sv
// Self-checking testbench for pin_blink_and_duty_controller_core, with a scoreboard class
// that mirrors the pin, timer and mode state. Needs pbd_pkg, the core RTL and pbd_mod_unit.
`timescale 1ns / 100ps

module pin_blink_and_duty_controller_core_test
    import pbd_pkg::*;
;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam int RANDOM_ITEMS   = 450;
    localparam int DUTY_TICKS     = 120;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    class pin_controller_mirror;
        logic [1:0]  active_mode;
        logic        pin_out;
        logic        timer_running;
        logic [15:0] period_ticks;
        logic [15:0] tick_counter;
        logic [7:0]  phase_count;
        logic [3:0]  duty_divisor;
        rsp_t        expected_results[$];
        int          failures;
        int          fires;
        int          param_errors;
        int          results_seen;

        function new();
            active_mode   = AM_STATIC;
            pin_out       = 1'b0;
            timer_running = 1'b0;
            period_ticks  = '0;
            tick_counter  = '0;
            phase_count   = '0;
            duty_divisor  = '0;
            failures      = 0;
            fires         = 0;
            param_errors  = 0;
            results_seen  = 0;
        endfunction

        function void predict_pin(req_t r);
            rsp_t want;
            int   next_count;
            int   divisor;
            want.status      = STATUS_OK;
            want.timer_fired = 1'b0;
            case (r.mode)
                MODE_TICK:
                begin
                    if (timer_running)
                    begin
                        next_count = int'(tick_counter) + 1;
                        if (next_count >= int'(period_ticks))
                        begin
                            tick_counter     = '0;
                            want.timer_fired = 1'b1;
                            fires++;
                            case (active_mode)
                                AM_TOGGLE: pin_out = ~pin_out;
                                AM_COUNT:
                                begin
                                    if (phase_count == 0)
                                    begin
                                        active_mode   = AM_STATIC;
                                        pin_out       = 1'b1;
                                        timer_running = 1'b0;
                                    end
                                    else
                                    begin
                                        pin_out = ~pin_out;
                                        if (!pin_out)
                                            phase_count = phase_count - 8'd1;
                                    end
                                end
                                AM_POWER:
                                begin
                                    divisor = (duty_divisor == 0) ? 1 : int'(duty_divisor);
                                    pin_out = ((int'(phase_count) % divisor) == 0);
                                    phase_count = phase_count + 8'd1;
                                    if (phase_count > PHASE_WRAP)
                                        phase_count = '0;
                                end
                                default: ;
                            endcase
                        end
                        else
                            tick_counter = 16'(next_count);
                    end
                end
                MODE_SET:
                begin
                    timer_running = 1'b0;
                    tick_counter  = '0;
                    active_mode   = AM_STATIC;
                    pin_out       = r.level;
                end
                MODE_TOGGLE:
                begin
                    if (r.period == 0)
                        want.status = STATUS_ERR;
                    else
                    begin
                        active_mode   = AM_TOGGLE;
                        period_ticks  = r.period;
                        tick_counter  = '0;
                        timer_running = 1'b1;
                    end
                end
                MODE_BLINK:
                begin
                    if (r.period == 0 || r.blink_count == 0)
                        want.status = STATUS_ERR;
                    else
                    begin
                        active_mode   = AM_COUNT;
                        phase_count   = r.blink_count;
                        pin_out       = 1'b1;
                        period_ticks  = r.period;
                        tick_counter  = '0;
                        timer_running = 1'b1;
                    end
                end
                MODE_DUTY:
                begin
                    if (r.power_level >= POWER_LIMIT)
                        want.status = STATUS_ERR;
                    else if (!(active_mode == AM_POWER &&
                               duty_divisor == POWER_LIMIT - r.power_level))
                    begin
                        active_mode   = AM_POWER;
                        duty_divisor  = POWER_LIMIT - r.power_level;
                        phase_count   = '0;
                        period_ticks  = POWER_PERIOD;
                        tick_counter  = '0;
                        timer_running = 1'b1;
                    end
                end
                default: want.status = STATUS_ERR;
            endcase
            if (want.status == STATUS_ERR)
                param_errors++;
            want.pin_level = pin_out;
            expected_results.push_back(want);
        endfunction

        function void check_pin_result(rsp_t got);
            rsp_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("Response arrived with no request pending.");
                failures++;
                return;
            end
            want = expected_results.pop_front();
            if (got.pin_level !== want.pin_level)
            begin
                $error("pin_level: expected %0b, got %0b", want.pin_level, got.pin_level);
                failures++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0b, got %0b", want.status, got.status);
                failures++;
            end
            if (got.timer_fired !== want.timer_fired)
            begin
                $error("timer_fired: expected %0b, got %0b", want.timer_fired, got.timer_fired);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    pin_controller_mirror mirror;
    int requests_sent = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    bit sender_idles = 1'b1;
    int stall_profile = 0;
    bit hold_requested = 1'b0;

    pin_blink_and_duty_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic req_t random_request();
        req_t r;
        r.mode        = 3'($urandom_range(0, 7));
        r.level       = 1'($urandom);
        r.period      = 16'($urandom);
        r.blink_count = 8'($urandom);
        r.power_level = 4'($urandom);
        return r;
    endfunction

    function automatic req_t make_request(logic [2:0] mode, logic level, logic [15:0] period,
                                          logic [7:0] count, logic [3:0] power);
        req_t r;
        r.mode        = mode;
        r.level       = level;
        r.period      = period;
        r.blink_count = count;
        r.power_level = power;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = sender_idles ? $urandom_range(1, 6) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        mirror.predict_pin(r);
        requests_sent++;
    endtask

    task automatic send_ticks(input int count);
        req_t t;
        repeat (count)
        begin
            t      = random_request();
            t.mode = MODE_TICK;
            send_request(t);
        end
    endtask

    initial
    begin
        int hold_left;
        int pattern_step;
        hold_left    = 0;
        pattern_step = 0;
        rsp_stall    = 1'b0;
        forever
        begin
            @(negedge clk);
            pattern_step++;
            if (hold_requested)
            begin
                hold_requested = 1'b0;
                hold_left      = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_profile == 1)
                rsp_stall <= ($urandom_range(0, 2) == 0);
            else if (stall_profile == 2)
                rsp_stall <= ((pattern_step % 8) < 3);
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && mirror != null && rsp_valid && !rsp_stall)
            mirror.check_pin_result(rsp);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        req_t       cmd;
        int         kind;
        int         ticks;
        int         start_count;
        logic [3:0] last_power;
        bit         hold_done;
        last_power = 4'd0;
        hold_done  = 1'b0;
        mirror     = new();
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(make_request(MODE_TICK, 1'b0, 16'd0, 8'd0, 4'd0));
        send_request(make_request(MODE_SET, 1'b1, 16'd0, 8'd0, 4'd0));
        send_request(make_request(MODE_SET, 1'b0, 16'd0, 8'd0, 4'd0));
        send_request(make_request(MODE_TOGGLE, 1'b0, 16'd0, 8'd0, 4'd0));
        send_request(make_request(MODE_TOGGLE, 1'b0, 16'hFFFF, 8'd0, 4'd0));
        send_ticks(1);
        send_request(make_request(MODE_TOGGLE, 1'b0, 16'd1, 8'd0, 4'd0));
        send_ticks(2);
        send_request(make_request(MODE_BLINK, 1'b0, 16'd0, 8'd3, 4'd0));
        send_request(make_request(MODE_BLINK, 1'b0, 16'd2, 8'd0, 4'd0));
        send_request(make_request(MODE_BLINK, 1'b0, 16'd1, 8'd1, 4'd0));
        send_ticks(3);
        send_request(make_request(MODE_BLINK, 1'b1, 16'hFFFF, 8'hFF, 4'd0));
        send_request(make_request(MODE_DUTY, 1'b0, 16'd0, 8'd0, 4'd10));
        send_request(make_request(MODE_DUTY, 1'b0, 16'd0, 8'd0, 4'hF));
        send_request(make_request(MODE_DUTY, 1'b0, 16'd0, 8'd0, 4'd9));
        send_request(make_request(MODE_DUTY, 1'b0, 16'd0, 8'd0, 4'd9));
        send_request(make_request(MODE_DUTY, 1'b0, 16'd0, 8'd0, 4'd0));
        send_request(make_request(3'd5, 1'b1, 16'hFFFF, 8'hFF, 4'hF));
        send_request(make_request(3'd6, 1'b0, 16'h0000, 8'h00, 4'h0));
        send_request(make_request(3'd7, 1'b1, 16'hFFFF, 8'hFF, 4'hF));
        send_request(make_request(MODE_SET, 1'b0, 16'd0, 8'd0, 4'd0));

        send_request(make_request(MODE_DUTY, 1'b0, 16'd0, 8'd0, 4'd5));
        send_ticks(DUTY_TICKS);

        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_ITEMS)
        begin
            if (!hold_done && requests_sent - start_count >= RANDOM_ITEMS / 3)
            begin
                hold_requested = 1'b1;
                hold_done      = 1'b1;
            end
            if ($urandom_range(0, 14) == 0)
            begin
                sender_idles  = ($urandom_range(0, 2) != 0);
                stall_profile = $urandom_range(0, 2);
            end
            cmd  = random_request();
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1:
                begin
                    cmd.mode   = MODE_TOGGLE;
                    cmd.period = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(1, 5));
                    ticks = $urandom_range(0, 15);
                end
                2, 3, 4:
                begin
                    cmd.mode        = MODE_BLINK;
                    cmd.period      = 16'($urandom_range(1, 3));
                    cmd.blink_count = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(1, 4));
                    ticks = 2 * int'(cmd.blink_count) * int'(cmd.period) + int'(cmd.period)
                            + $urandom_range(0, 3);
                    if (ticks > 60)
                        ticks = $urandom_range(0, 60);
                end
                5, 6:
                begin
                    cmd.mode        = MODE_DUTY;
                    cmd.power_level = ($urandom_range(0, 5) == 0) ? 4'($urandom)
                                                                  : 4'($urandom_range(0, 9));
                    if ($urandom_range(0, 3) == 0)
                        cmd.power_level = last_power;
                    last_power = cmd.power_level;
                    ticks = $urandom_range(5, 40);
                end
                7:
                begin
                    cmd.mode = MODE_SET;
                    ticks = $urandom_range(0, 3);
                end
                default: ticks = $urandom_range(0, 4);
            endcase
            send_request(cmd);
            send_ticks(ticks);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        while (mirror.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses, %0d timer fires, %0d flagged.",
                 requests_sent, mirror.results_seen, mirror.fires, mirror.param_errors);
        $display("Run included every command, duty steps and a long response hold-off.");
        if (mirror.failures == 0 && mirror.expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
